/* rtl/core/hsv_to_rgb_converter_top_macros.svh */
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion forms for the converter's pipeline checks.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Payload types and fixed-point constants shared by the converter modules.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HueW     = 16;
  localparam int FracW    = 9;
  localparam int ChanW    = 8;
  localparam int HueLoW   = 7;
  localparam int HueHiW   = HueW - HueLoW;
  localparam int HueRedW  = 13;
  localparam int WeightW  = 10;
  localparam int SvW      = 2 * FracW;
  localparam int MscW     = SvW + 1;
  localparam int ProdW    = SvW + WeightW;
  localparam int MsW      = ProdW + 2;
  localparam int NumW     = MsW + 1;
  localparam int Stages   = 6;

  localparam int HueRecip      = 91;
  localparam int HueRecipShift = 12;
  localparam int HueBlock      = 45;
  localparam int HueTurn       = 5760;
  localparam int SectorLen     = 960;
  localparam int RoundShift    = 22;
  localparam int ChanMax       = 255;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [FracW-1:0] saturation;
    logic [FracW-1:0] brightness;
  } hsvrgb_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } hsvrgb_out_t;

endpackage

/* rtl/core/hsvrgb_chan_round.sv */
// ----------------------------------------------------------------------------
// HSV to RGB channel rounding
// Scales one channel numerator to 8 bits, rounds half up and clamps to 0..255.
// ----------------------------------------------------------------------------
module hsvrgb_chan_round import hsvrgb_pkg::*; (
  input  logic signed [NumW-1:0] num_i,
  output logic [ChanW-1:0]       chan_o
);

  localparam int SumW = NumW + 3;
  localparam int QW   = SumW - RoundShift;
  localparam logic [SumW-1:0] Half = SumW'(1) << (RoundShift - 1);

  logic [NumW-2:0] mag;
  logic [SumW-1:0] scaled;
  logic [QW-1:0]   quot;

  // The numerator's full scale is 15 * 2^22, so one channel step is 2^22 / 17
  // and the result is the numerator times 17 shifted down by 22 with rounding.
  always_comb begin
    mag    = num_i[NumW-2:0];
    scaled = {mag, 4'b0000} + {4'b0000, mag} + Half;
    quot   = scaled[SumW-1:RoundShift];
    if (num_i[NumW-1] || (num_i == '0)) begin
      chan_o = '0;
    end else if (quot > QW'(ChanMax)) begin
      chan_o = ChanW'(ChanMax);
    end else begin
      chan_o = quot[ChanW-1:0];
    end
  end

endmodule

/* rtl/core/hsv_to_rgb_converter_top.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Throughput: one transaction per cycle unless stalled; six-stage register pipeline.
// Stall: each stage holds its data while the stage after it is full and stalled.
// Reset: asynchronous, active low, clears all stage valid bits.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_top_macros.svh"

module hsv_to_rgb_converter_top import hsvrgb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hsvrgb_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hsvrgb_out_t out_data_o
);

  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] ld;

  always_comb begin
    ld[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      ld[k] = !valid_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ld[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (ld[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: estimate hue turns and form S*V.
  logic [HueHiW-1:0] s1_h9_q;
  logic [HueLoW-1:0] s1_hlo_q;
  logic [3:0]        s1_qe_q;
  logic [SvW-1:0]    s1_sv_q;
  logic [FracW-1:0]  s1_v_q;
  logic [15:0]       s1_prod;

  assign s1_prod = 16'(in_data_i.hue[HueW-1:HueLoW]) * 16'(HueRecip);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s1_h9_q  <= in_data_i.hue[HueW-1:HueLoW];
      s1_hlo_q <= in_data_i.hue[HueLoW-1:0];
      s1_qe_q  <= s1_prod[15:HueRecipShift];
      s1_sv_q  <= SvW'(in_data_i.saturation) * SvW'(in_data_i.brightness);
      s1_v_q   <= in_data_i.brightness;
    end
  end

  // Stage 2: reduced hue and the M term before scaling.
  logic [HueRedW-1:0]     s2_hm_q;
  logic [SvW-1:0]         s2_sv_q;
  logic signed [MscW-1:0] s2_msc_q;
  logic [9:0]             s2_q45;
  logic [9:0]             s2_rem_full;
  logic [6:0]             s2_rem7;
  logic [5:0]             s2_rem6;

  always_comb begin
    s2_q45      = {6'b000000, s1_qe_q} * 10'(HueBlock);
    s2_rem_full = {1'b0, s1_h9_q} - s2_q45;
    s2_rem7     = s2_rem_full[6:0];
    s2_rem6     = (s2_rem7 >= 7'(HueBlock)) ? 6'(s2_rem7 - 7'(HueBlock)) : s2_rem7[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s2_hm_q  <= {s2_rem6, s1_hlo_q};
      s2_sv_q  <= s1_sv_q;
      s2_msc_q <= $signed({2'b00, s1_v_q, 8'h00}) - $signed({1'b0, s1_sv_q});
    end
  end

  // Stage 3: sector and triangle weight.
  sector_e                s3_sector_q;
  logic [WeightW-1:0]     s3_w_q;
  logic [SvW-1:0]         s3_sv_q;
  logic signed [MscW-1:0] s3_msc_q;
  sector_e                s3_sector;
  logic [HueRedW-1:0]     s3_base;
  logic [HueRedW-1:0]     s3_off;
  logic [WeightW-1:0]     s3_w;

  always_comb begin
    if (s2_hm_q >= HueRedW'(5 * SectorLen)) begin
      s3_sector = SecMagRed;
    end else if (s2_hm_q >= HueRedW'(4 * SectorLen)) begin
      s3_sector = SecBluMag;
    end else if (s2_hm_q >= HueRedW'(3 * SectorLen)) begin
      s3_sector = SecCynBlu;
    end else if (s2_hm_q >= HueRedW'(2 * SectorLen)) begin
      s3_sector = SecGrnCyn;
    end else if (s2_hm_q >= HueRedW'(SectorLen)) begin
      s3_sector = SecYelGrn;
    end else begin
      s3_sector = SecRedYel;
    end
    s3_base = HueRedW'(s3_sector) * HueRedW'(SectorLen);
    s3_off  = s2_hm_q - s3_base;
    unique case (s3_sector) inside
      SecYelGrn, SecCynBlu, SecMagRed: s3_w = WeightW'(SectorLen) - s3_off[WeightW-1:0];
      default:                         s3_w = s3_off[WeightW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      s3_sector_q <= s3_sector;
      s3_w_q      <= s3_w;
      s3_sv_q     <= s2_sv_q;
      s3_msc_q    <= s2_msc_q;
    end
  end

  // Stage 4: C, X and M numerators over 65536 * 960.
  sector_e               s4_sector_q;
  logic [ProdW-1:0]      s4_cs_q;
  logic [ProdW-1:0]      s4_xs_q;
  logic signed [MsW-1:0] s4_ms_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s4_sector_q <= s3_sector_q;
      s4_cs_q     <= ProdW'(s3_sv_q) * ProdW'(SectorLen);
      s4_xs_q     <= ProdW'(s3_sv_q) * ProdW'(s3_w_q);
      s4_ms_q     <= MsW'(s3_msc_q) * MsW'(SectorLen);
    end
  end

  // Stage 5: channel numerators.
  logic signed [NumW-1:0] s5_r_q;
  logic signed [NumW-1:0] s5_g_q;
  logic signed [NumW-1:0] s5_b_q;
  logic signed [NumW-1:0] s5_c;
  logic signed [NumW-1:0] s5_x;
  logic signed [NumW-1:0] s5_z;
  logic signed [NumW-1:0] s5_r;
  logic signed [NumW-1:0] s5_g;
  logic signed [NumW-1:0] s5_b;

  always_comb begin
    s5_z = NumW'(s4_ms_q);
    s5_c = $signed({3'b000, s4_cs_q}) + s5_z;
    s5_x = $signed({3'b000, s4_xs_q}) + s5_z;
    unique case (s4_sector_q)
      SecRedYel: begin s5_r = s5_c; s5_g = s5_x; s5_b = s5_z; end
      SecYelGrn: begin s5_r = s5_x; s5_g = s5_c; s5_b = s5_z; end
      SecGrnCyn: begin s5_r = s5_z; s5_g = s5_c; s5_b = s5_x; end
      SecCynBlu: begin s5_r = s5_z; s5_g = s5_x; s5_b = s5_c; end
      SecBluMag: begin s5_r = s5_x; s5_g = s5_z; s5_b = s5_c; end
      default:   begin s5_r = s5_c; s5_g = s5_z; s5_b = s5_x; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      s5_r_q <= s5_r;
      s5_g_q <= s5_g;
      s5_b_q <= s5_b;
    end
  end

  // Stage 6: rounding, clamping and the output register.
  hsvrgb_out_t s6_out;
  hsvrgb_out_t s6_out_q;

  hsvrgb_chan_round u_round_r (.num_i(s5_r_q), .chan_o(s6_out.red));
  hsvrgb_chan_round u_round_g (.num_i(s5_g_q), .chan_o(s6_out.green));
  hsvrgb_chan_round u_round_b (.num_i(s5_b_q), .chan_o(s6_out.blue));

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s6_out_q <= s6_out;
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = valid_q[Stages-1];
  assign out_data_o  = s6_out_q;

  `HSVRGB_ASSERT_IMP(a_hue_reduced, clk_i, rst_ni, valid_q[1], s2_hm_q < HueRedW'(HueTurn), "reduced hue out of range")
  `HSVRGB_ASSERT_IMP(a_weight_range, clk_i, rst_ni, valid_q[2], s3_w_q <= WeightW'(SectorLen), "hue weight out of range")
  `HSVRGB_ASSERT_NXT(a_stage_hold, clk_i, rst_ni, valid_q[3] && !ld[3], valid_q[3], "stalled stage lost its transaction")
  `HSVRGB_ASSERT_NXT(a_input_enters, clk_i, rst_ni, in_valid_i && in_ready_o, valid_q[0], "accepted transaction not captured")

endmodule
